// ----- hw/rtl/ill_pkg.sv -----
// Shared types and constants for the indexed linked-list engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package ill_pkg;

  // Store geometry.
  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LINK_W = $clog2(DEPTH + 1);

  // Field widths of a request and of a result.
  localparam int MODE_W = 2;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 3;

  // Stream bus widths, rounded up to whole bytes.
  localparam int IN_W  = ((MODE_W + POS_W + VAL_W + 7) / 8) * 8;
  localparam int OUT_W = ((STAT_W + VAL_W + 7) / 8) * 8;

  // A link that points nowhere.
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(DEPTH);

  typedef enum logic [MODE_W-1:0] {
    MODE_HEAD_INS  = 2'd0,
    MODE_INS_AFTER = 2'd1,
    MODE_DEL_AFTER = 2'd2,
    MODE_DUMP      = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE    = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_ELEM    = 3'd2,
    STAT_EMPTY   = 3'd3,
    STAT_ILLEGAL = 3'd4
  } status_t;

  // Address source of a link/value memory read.
  typedef enum logic [1:0] {
    RD_SRC_REF  = 2'd0,
    RD_SRC_HEAD = 2'd1,
    RD_SRC_LINK = 2'd2
  } rd_src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_INS_A,
    ST_INS_B,
    ST_DEL_HEAD,
    ST_DEL_SUCC,
    ST_DEL_WR,
    ST_DUMP,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    in_load;         // capture the incoming request
    logic    rd_en;           // read link and value memories
    rd_src_t rd_src;
    logic    node_wr;         // write a new node at slot nodes_used
    logic    node_link_head;  // new node links to the head, else to the read link
    logic    used_inc;
    logic    ref_wr;          // rewrite the link of the reference node
    logic    ref_from_used;   // that link becomes nodes_used, else the read link
    logic    head_wr;
    logic    head_from_used;  // head becomes nodes_used, else the read link
    logic    cnt_clr;
    logic    out_load;
    logic    out_elem;        // result is a list element from the read data
    status_t out_status;
  } ill_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    mode_t mode;
    logic  pos_zero;
    logic  pos_over;   // position beyond the nodes inserted so far
    logic  full;
    logic  head_null;
    logic  link_null;  // read link points nowhere
    logic  cnt_last;   // walk has produced DEPTH-1 elements
    logic  out_free;
  } ill_stat_t;

endpackage

// ----- hw/rtl/indexed_linked_list_engine_unit.sv -----
// Indexed linked-list engine: a singly linked list held in node memories.
// Requests enter on the s_axis channel; results leave on m_axis.
// Each request carries a mode: head insert, insert after the k-th inserted
// node, delete the successor of the k-th node (k = 0 deletes the head), or
// dump the list. A mutation returns one status result with tlast set; a dump
// returns one result per element, head to tail, tlast on the tail, or one
// "list empty" result.
// Sequence: a request is taken while idle and checked in the next cycle. A head
// insert or a refused request then loads its result; a delete first unlinks the
// head, or fetches the successor's link and rewrites the reference link; an
// insert writes the new node, then the reference link. A dump loads one
// element every cycle while the receiver takes them, head to tail, reading
// the link memory once per node. The next request is taken the cycle after
// the last result is loaded into the output register. Reset empties the list
// and the fill count at once; node memories need no clearing. When the
// receiver stalls, the output register holds its result and the dump walk waits with it.
// Depends on ill_pkg, ill_ctrl and ill_datapath.
module indexed_linked_list_engine_unit
  import ill_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // mode[1:0], position[8:2], value_in[40:9]
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // status[2:0], value_out[34:3]
  output logic             m_axis_tlast
);

  ill_cmd_t  cmd;
  ill_stat_t stat;

  // Sequencer.
  ill_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Node store and result register.
  ill_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_tdata  (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_tdata (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

// ----- hw/rtl/ill_ctrl.sv -----
// Controller state machine of the linked-list engine.
// Depends on ill_pkg; drives the datapath through ill_cmd_t.
module ill_ctrl
  import ill_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ill_stat_t stat,
  output ill_cmd_t  cmd
);

  state_t  state, state_next;
  status_t ret_status, ret_status_next;

  // State and pending status registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ret_status <= STAT_DONE;
    end else begin
      state      <= state_next;
      ret_status <= ret_status_next;
    end
  end

  // Next state and the status to report.
  always_comb begin
    state_next      = state;
    ret_status_next = ret_status;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        unique case (stat.mode)
          MODE_HEAD_INS: begin
            ret_status_next = stat.full ? STAT_FULL : STAT_DONE;
            state_next      = ST_EMIT;
          end
          MODE_INS_AFTER: begin
            if (stat.pos_zero || stat.pos_over) begin
              ret_status_next = STAT_ILLEGAL;
              state_next      = ST_EMIT;
            end else if (stat.full) begin
              ret_status_next = STAT_FULL;
              state_next      = ST_EMIT;
            end else begin
              state_next = ST_INS_A;
            end
          end
          MODE_DEL_AFTER: begin
            if (stat.pos_zero) begin
              if (stat.head_null) begin
                ret_status_next = STAT_ILLEGAL;
                state_next      = ST_EMIT;
              end else begin
                state_next = ST_DEL_HEAD;
              end
            end else if (stat.pos_over) begin
              ret_status_next = STAT_ILLEGAL;
              state_next      = ST_EMIT;
            end else begin
              state_next = ST_DEL_SUCC;
            end
          end
          MODE_DUMP: begin
            if (stat.head_null) begin
              ret_status_next = STAT_EMPTY;
              state_next      = ST_EMIT;
            end else begin
              state_next = ST_DUMP;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_INS_A: state_next = ST_INS_B;
      ST_INS_B: begin
        ret_status_next = STAT_DONE;
        state_next      = ST_EMIT;
      end
      ST_DEL_HEAD: begin
        ret_status_next = STAT_DONE;
        state_next      = ST_EMIT;
      end
      ST_DEL_SUCC: begin
        if (stat.link_null) begin
          ret_status_next = STAT_ILLEGAL;
          state_next      = ST_EMIT;
        end else begin
          state_next = ST_DEL_WR;
        end
      end
      ST_DEL_WR: begin
        ret_status_next = STAT_DONE;
        state_next      = ST_EMIT;
      end
      ST_DUMP: begin
        if (stat.out_free && (stat.link_null || stat.cnt_last)) state_next = ST_IDLE;
      end
      ST_EMIT: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.in_load = in_valid;
      end
      ST_CHECK: begin
        unique case (stat.mode)
          MODE_HEAD_INS: begin
            if (!stat.full) begin
              cmd.node_wr        = 1'b1;
              cmd.node_link_head = 1'b1;
              cmd.head_wr        = 1'b1;
              cmd.head_from_used = 1'b1;
              cmd.used_inc       = 1'b1;
            end
          end
          MODE_INS_AFTER: begin
            if (!(stat.pos_zero || stat.pos_over || stat.full)) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = RD_SRC_REF;
            end
          end
          MODE_DEL_AFTER: begin
            if (stat.pos_zero) begin
              cmd.rd_en  = !stat.head_null;
              cmd.rd_src = RD_SRC_HEAD;
            end else begin
              cmd.rd_en  = !stat.pos_over;
              cmd.rd_src = RD_SRC_REF;
            end
          end
          MODE_DUMP: begin
            cmd.rd_en   = !stat.head_null;
            cmd.rd_src  = RD_SRC_HEAD;
            cmd.cnt_clr = 1'b1;
          end
          default: cmd.rd_en = 1'b0;
        endcase
      end
      // New node takes the reference node's old successor.
      ST_INS_A: begin
        cmd.node_wr = 1'b1;
      end
      // Reference node now points at the new node.
      ST_INS_B: begin
        cmd.ref_wr        = 1'b1;
        cmd.ref_from_used = 1'b1;
        cmd.used_inc      = 1'b1;
      end
      ST_DEL_HEAD: begin
        cmd.head_wr = 1'b1;
      end
      // Fetch the successor's link.
      ST_DEL_SUCC: begin
        cmd.rd_en  = !stat.link_null;
        cmd.rd_src = RD_SRC_LINK;
      end
      ST_DEL_WR: begin
        cmd.ref_wr = 1'b1;
      end
      // One element per free output slot; fetch the next node meanwhile.
      ST_DUMP: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_elem   = 1'b1;
          cmd.out_status = STAT_ELEM;
          cmd.rd_en      = !(stat.link_null || stat.cnt_last);
          cmd.rd_src     = RD_SRC_LINK;
        end
      end
      ST_EMIT: begin
        cmd.out_load   = stat.out_free;
        cmd.out_status = ret_status;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- hw/rtl/ill_datapath.sv -----
// Datapath of the linked-list engine: node memories, list registers and result register.
// Depends on ill_pkg; steered by ill_cmd_t from ill_ctrl.
module ill_datapath
  import ill_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  ill_cmd_t         cmd,
  output ill_stat_t        stat,
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_last
);

  logic [VAL_W-1:0]  node_values [DEPTH];
  logic [LINK_W-1:0] node_links  [DEPTH];

  mode_t             req_mode;
  logic [POS_W-1:0]  req_position;
  logic [VAL_W-1:0]  req_value;
  logic [LINK_W-1:0] head_link;
  logic [LINK_W-1:0] nodes_used;
  logic [LINK_W-1:0] walk_count;
  logic [LINK_W-1:0] rd_link;
  logic [VAL_W-1:0]  rd_value;
  status_t           out_status;
  logic [VAL_W-1:0]  out_value;

  logic [POS_W-1:0]  pos_minus;
  logic [ADDR_W-1:0] ref_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] lnk_waddr;
  logic [LINK_W-1:0] lnk_wdata;
  logic              lnk_we;
  logic              link_null;
  logic              out_free;

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      req_mode     <= mode_t'(in_tdata[MODE_W-1:0]);
      req_position <= in_tdata[MODE_W +: POS_W];
      req_value    <= in_tdata[MODE_W+POS_W +: VAL_W];
    end
  end

  assign pos_minus = req_position - POS_W'(1);
  assign ref_addr  = pos_minus[ADDR_W-1:0];
  assign link_null = (rd_link >= NULL_LINK);
  assign out_free  = !out_valid || out_ready;

  // Read address selection.
  always_comb begin
    case (cmd.rd_src)
      RD_SRC_REF:  rd_addr = ref_addr;
      RD_SRC_HEAD: rd_addr = head_link[ADDR_W-1:0];
      RD_SRC_LINK: rd_addr = rd_link[ADDR_W-1:0];
      default:     rd_addr = ref_addr;
    endcase
  end

  // Single write port of the link memory: new node or reference node.
  assign lnk_we    = cmd.node_wr || cmd.ref_wr;
  assign lnk_waddr = cmd.node_wr ? nodes_used[ADDR_W-1:0] : ref_addr;
  always_comb begin
    if (cmd.node_wr) begin
      lnk_wdata = cmd.node_link_head ? head_link : rd_link;
    end else begin
      lnk_wdata = cmd.ref_from_used ? nodes_used : rd_link;
    end
  end

  // Node memories with registered reads.
  always_ff @(posedge clk) begin
    if (lnk_we) begin
      node_links[lnk_waddr] <= lnk_wdata;
    end
    if (cmd.node_wr) begin
      node_values[nodes_used[ADDR_W-1:0]] <= req_value;
    end
    if (cmd.rd_en) begin
      rd_link  <= node_links[rd_addr];
      rd_value <= node_values[rd_addr];
    end
  end

  // List head, fill count and walk count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_link  <= NULL_LINK;
      nodes_used <= '0;
      walk_count <= '0;
    end else begin
      if (cmd.head_wr) begin
        head_link <= cmd.head_from_used ? nodes_used : rd_link;
      end
      if (cmd.used_inc) begin
        nodes_used <= nodes_used + LINK_W'(1);
      end
      if (cmd.cnt_clr) begin
        walk_count <= '0;
      end else if (cmd.out_load && cmd.out_elem) begin
        walk_count <= walk_count + LINK_W'(1);
      end
    end
  end

  // Result register: holds one result while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.out_status;
      out_value  <= cmd.out_elem ? rd_value : '0;
      out_last   <= cmd.out_elem ? (link_null || stat.cnt_last) : 1'b1;
    end
  end

  assign out_tdata = {(OUT_W - STAT_W - VAL_W)'(0), out_value, out_status};

  // Status to the controller.
  always_comb begin
    stat.mode      = req_mode;
    stat.pos_zero  = (req_position == '0);
    stat.pos_over  = (req_position > POS_W'(nodes_used));
    stat.full      = (nodes_used >= LINK_W'(DEPTH));
    stat.head_null = (head_link >= NULL_LINK);
    stat.link_null = link_null;
    stat.cnt_last  = (walk_count == LINK_W'(DEPTH - 1));
    stat.out_free  = out_free;
  end

`ifndef SYNTHESIS
  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.node_wr |-> !stat.full)
    else $error("new node written into a full store");

  a_one_link_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.node_wr && cmd.ref_wr))
    else $error("two link writes in one cycle");

  a_load_into_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result register overwritten while still held");

  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= LINK_W'(DEPTH))
    else $error("fill count beyond store depth");

  a_used_grows_by_one: assert property (@(posedge clk) disable iff (rst)
    cmd.used_inc |=> nodes_used == $past(nodes_used) + LINK_W'(1))
    else $error("fill count did not advance by one");
`endif

endmodule

// ----- sim/tb_indexed_linked_list_engine_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the indexed linked-list engine.
// A scoreboard class predicts every result from the accepted requests.
// Depends on ill_pkg and indexed_linked_list_engine_unit.
module tb_indexed_linked_list_engine_unit;
  import ill_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 180;

  typedef struct packed {
    status_t           status;
    logic [VAL_W-1:0]  value;
    logic              last;
  } list_result_t;

  // Scoreboard: keeps its own copy of the node store and predicts each result.
  class list_scoreboard;
    logic [VAL_W-1:0]  node_val [DEPTH];
    logic [LINK_W-1:0] node_next [DEPTH];
    logic [LINK_W-1:0] head_slot;
    int                fill_count;
    list_result_t      expected_q[$];
    int                mismatches;
    int                mode_hits [4];
    int                results_seen;
    int                elements_seen;
    int                full_seen;
    int                illegal_seen;

    function new();
      head_slot     = NULL_LINK;
      fill_count    = 0;
      mismatches    = 0;
      results_seen  = 0;
      elements_seen = 0;
      full_seen     = 0;
      illegal_seen  = 0;
      foreach (mode_hits[i]) mode_hits[i] = 0;
    endfunction

    function void push_result(status_t st, logic [VAL_W-1:0] v, logic l);
      list_result_t r;
      r.status = st;
      r.value  = v;
      r.last   = l;
      expected_q.push_back(r);
    endfunction

    // Apply an accepted request to the local store and queue its results.
    function void note_request(mode_t m, logic [POS_W-1:0] p, logic [VAL_W-1:0] v);
      status_t           st;
      int                ref_slot;
      int                walk;
      int                count;
      logic [LINK_W-1:0] succ;
      logic [LINK_W-1:0] nxt;
      st = STAT_DONE;
      mode_hits[m]++;
      case (m)
        MODE_HEAD_INS: begin
          if (fill_count >= DEPTH) begin
            st = STAT_FULL;
          end else begin
            node_val[fill_count]  = v;
            node_next[fill_count] = head_slot;
            head_slot             = LINK_W'(fill_count);
            fill_count++;
          end
        end
        MODE_INS_AFTER: begin
          if (p == 0 || int'(p) > fill_count) begin
            st = STAT_ILLEGAL;
          end else if (fill_count >= DEPTH) begin
            st = STAT_FULL;
          end else begin
            ref_slot              = int'(p) - 1;
            node_val[fill_count]  = v;
            node_next[fill_count] = node_next[ref_slot];
            node_next[ref_slot]   = LINK_W'(fill_count);
            fill_count++;
          end
        end
        MODE_DEL_AFTER: begin
          if (p == 0) begin
            if (head_slot >= DEPTH) st = STAT_ILLEGAL;
            else head_slot = node_next[head_slot];
          end else if (int'(p) > fill_count) begin
            st = STAT_ILLEGAL;
          end else begin
            ref_slot = int'(p) - 1;
            succ     = node_next[ref_slot];
            if (succ >= DEPTH) st = STAT_ILLEGAL;
            else node_next[ref_slot] = node_next[succ];
          end
        end
        default: begin
          // Walk from the head; the tail element carries the last flag.
          if (head_slot >= DEPTH) begin
            push_result(STAT_EMPTY, '0, 1'b1);
          end else begin
            walk  = head_slot;
            count = 0;
            while (walk < DEPTH && count < DEPTH) begin
              nxt = node_next[walk];
              push_result(STAT_ELEM, node_val[walk], (nxt >= DEPTH) || (count + 1 >= DEPTH));
              count++;
              walk = nxt;
            end
          end
          return;
        end
      endcase
      push_result(st, '0, 1'b1);
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(logic [STAT_W-1:0] st, logic [VAL_W-1:0] v, logic l);
      list_result_t exp_r;
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("Result with nothing expected: status %0d value %0h last %0b", st, v, l);
        mismatches++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (exp_r.status == STAT_ELEM) elements_seen++;
      if (exp_r.status == STAT_FULL) full_seen++;
      if (exp_r.status == STAT_ILLEGAL) illegal_seen++;
      if (st !== exp_r.status) begin
        $error("status: expected %0d, actual %0d", exp_r.status, st);
        mismatches++;
      end
      if (v !== exp_r.value) begin
        $error("value_out: expected %0h, actual %0h", exp_r.value, v);
        mismatches++;
      end
      if (l !== exp_r.last) begin
        $error("last: expected %0b, actual %0b", exp_r.last, l);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;   // mode[1:0], position[8:2], value_in[40:9]
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;   // status[2:0], value_out[34:3]
  logic             m_axis_tlast;

  list_scoreboard sb;
  int             burst_left;
  int             ready_left;
  int             stall_cycles;

  indexed_linked_list_engine_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver stalls: short random stalls mixed with long stretches of ready.
  always @(negedge clk) begin
    int pick;
    logic level;
    level = m_axis_tready;
    if (ready_left == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        level      = 1'b0;
        ready_left = $urandom_range(1, 6);
      end else if (pick == 3) begin
        level      = 1'b1;
        ready_left = $urandom_range(20, 60);
      end else begin
        level      = 1'b1;
        ready_left = $urandom_range(1, 4);
      end
    end
    ready_left--;
    m_axis_tready <= level;
  end

  // Result monitor and watchdog.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[STAT_W-1:0], m_axis_tdata[STAT_W +: VAL_W], m_axis_tlast);
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no request or result moved for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // Send one request, pacing the sender in bursts separated by random gaps.
  task automatic issue_request(input mode_t m, input logic [POS_W-1:0] p,
                               input logic [VAL_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({v, p, m});
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(m, p, v);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly positions of existing nodes; the rest anywhere from 0 to DEPTH.
  function automatic logic [POS_W-1:0] pick_position(mode_t m, int used);
    int pick;
    pick = $urandom_range(0, 99);
    if (m == MODE_DEL_AFTER && pick < 15) return '0;
    if (pick < 88 && used > 0) return POS_W'($urandom_range(1, used));
    return POS_W'($urandom_range(0, DEPTH));
  endfunction

  initial begin
    int    pick;
    mode_t m;
    sb            = new();
    burst_left    = 0;
    ready_left    = 0;
    stall_cycles  = 0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: empty-list cases, extreme values, stale reference nodes.
    issue_request(MODE_DUMP,      7'd0,  32'h1234_5678);
    issue_request(MODE_DEL_AFTER, 7'd0,  32'h0);
    issue_request(MODE_INS_AFTER, 7'd0,  32'h1);
    issue_request(MODE_INS_AFTER, 7'd1,  32'h2);
    issue_request(MODE_DEL_AFTER, 7'd1,  32'h0);
    issue_request(MODE_DEL_AFTER, 7'd64, 32'h0);
    issue_request(MODE_HEAD_INS,  7'd0,  32'h8000_0000);
    issue_request(MODE_HEAD_INS,  7'd64, 32'h7FFF_FFFF);
    issue_request(MODE_INS_AFTER, 7'd1,  32'h0000_0000);
    issue_request(MODE_INS_AFTER, 7'd3,  32'hFFFF_FFFF);
    issue_request(MODE_DUMP,      7'd127, 32'hFFFF_FFFF);
    // The tail node has no successor to delete.
    issue_request(MODE_DEL_AFTER, 7'd4,  32'h0);
    issue_request(MODE_DEL_AFTER, 7'd0,  32'h0);
    // Node 2 is gone from the list; these act on its stale link only.
    issue_request(MODE_INS_AFTER, 7'd2,  32'h5555_5555);
    issue_request(MODE_DEL_AFTER, 7'd2,  32'h0);
    issue_request(MODE_INS_AFTER, 7'd5,  32'hAAAA_AAAA);
    issue_request(MODE_DUMP,      7'd0,  32'h0);
    issue_request(MODE_INS_AFTER, 7'd64, 32'h0);
    issue_request(MODE_DEL_AFTER, 7'd1,  32'h0);
    issue_request(MODE_DUMP,      7'd0,  32'h0);

    // Random part: enough inserts to fill the store well before the end.
    repeat (RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 22)      m = MODE_HEAD_INS;
      else if (pick < 47) m = MODE_INS_AFTER;
      else if (pick < 82) m = MODE_DEL_AFTER;
      else                m = MODE_DUMP;
      issue_request(m, pick_position(m, sb.fill_count), pick_value());
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Requests: %0d head inserts, %0d inserts after, %0d deletes, %0d dumps.",
             sb.mode_hits[MODE_HEAD_INS], sb.mode_hits[MODE_INS_AFTER],
             sb.mode_hits[MODE_DEL_AFTER], sb.mode_hits[MODE_DUMP]);
    $display("Results: %0d checked, %0d list elements, %0d store full, %0d illegal.",
             sb.results_seen, sb.elements_seen, sb.full_seen, sb.illegal_seen);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
